### rtl/core/stb_pkg.sv
// Shared types, constants and helper functions of the source byte tokenizer.
package stb_pkg;

  localparam int POS_BITS = 16;
  localparam int KW_CHARS = 6;
  localparam int KW_IB = $clog2(KW_CHARS);
  localparam int VAL_BITS = 63;
  localparam int KIND_BITS = 6;
  localparam int ERR_BITS = 2;
  localparam int KW_COUNT = 11;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [VAL_BITS-1:0] VAL_MAX = '1;

  typedef enum logic [KIND_BITS-1:0] {
    K_NUMBER = 6'd0, K_IDENT = 6'd1, K_FUNC = 6'd2,
    K_PLUS = 6'd13, K_MINUS = 6'd14, K_STAR = 6'd15, K_SLASH = 6'd16,
    K_PERCENT = 6'd17, K_BANG = 6'd18, K_ASSIGN = 6'd19, K_EQ = 6'd20,
    K_NE = 6'd21, K_LT = 6'd22, K_LE = 6'd23, K_GT = 6'd24, K_GE = 6'd25,
    K_AND = 6'd26, K_OR = 6'd27, K_LPAREN = 6'd28, K_RPAREN = 6'd29,
    K_LBRACE = 6'd30, K_RBRACE = 6'd31, K_LBRACKET = 6'd32,
    K_RBRACKET = 6'd33, K_SEMI = 6'd34, K_COLON = 6'd35, K_COMMA = 6'd36,
    K_ARROW = 6'd37, K_EOF = 6'd38, K_ERROR = 6'd39
  } kind_t;

  typedef enum logic [ERR_BITS-1:0] {
    E_NONE = 2'd0, E_UNEXPECTED = 2'd1, E_UNTERMINATED = 2'd2
  } err_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [POS_BITS-1:0] line;
    logic [POS_BITS-1:0] col;
    logic [POS_BITS-1:0] len;
    logic [VAL_BITS-1:0] value;
    logic [ERR_BITS-1:0] err;
    logic last;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t first;
    tok_t second;
  } push_t;

  typedef logic [KW_CHARS-1:0][7:0] window_t;

  localparam logic [63:0] KW_STR [KW_COUNT] = '{
    64'("func"), 64'("let"), 64'("if"), 64'("else"), 64'("while"),
    64'("return"), 64'("print"), 64'("int"), 64'("bool"), 64'("true"),
    64'("false")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd3, 4'd2, 4'd4, 4'd5, 4'd6, 4'd5, 4'd3, 4'd4, 4'd4, 4'd5
  };

  function automatic tok_t mk_tok(kind_t kind, logic [POS_BITS-1:0] line,
                                  logic [POS_BITS-1:0] col,
                                  logic [POS_BITS-1:0] len,
                                  logic [VAL_BITS-1:0] value, err_t err);
    tok_t t;
    t.kind = kind;
    t.line = line;
    t.col = col;
    t.len = len;
    t.value = value;
    t.err = err;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic logic [POS_BITS-1:0] sat_inc(logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_BITS'(1);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic kind_t ident_kind(window_t w, logic [POS_BITS-1:0] run);
    kind_t k;
    logic hit;
    logic [7:0] want;
    k = K_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      hit = (run == POS_BITS'(KW_LEN[i]));
      for (int j = 0; j < KW_CHARS; j++) begin
        want = (j < int'(KW_LEN[i])) ? KW_STR[i][8*(int'(KW_LEN[i])-1-j) +: 8] : 8'd0;
        if (w[j] != want) hit = 1'b0;
      end
      if (hit) k = kind_t'(KIND_BITS'(int'(K_FUNC) + i));
    end
    return k;
  endfunction

  function automatic kind_t single_op(logic [7:0] p);
    case (p)
      "-": return K_MINUS;
      "!": return K_BANG;
      "=": return K_ASSIGN;
      "<": return K_LT;
      ">": return K_GT;
      default: return K_SLASH;
    endcase
  endfunction

  function automatic kind_t double_op(logic [7:0] p);
    case (p)
      "-": return K_ARROW;
      "!": return K_NE;
      "=": return K_EQ;
      "<": return K_LE;
      ">": return K_GE;
      "&": return K_AND;
      default: return K_OR;
    endcase
  endfunction

  function automatic logic is_single(logic [7:0] c);
    case (c)
      "(", ")", "{", "}", "[", "]", ";", ":", ",", "+", "*", "%": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic kind_t single_kind(logic [7:0] c);
    case (c)
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      "[": return K_LBRACKET;
      "]": return K_RBRACKET;
      ";": return K_SEMI;
      ":": return K_COLON;
      ",": return K_COMMA;
      "+": return K_PLUS;
      "*": return K_STAR;
      default: return K_PERCENT;
    endcase
  endfunction

endpackage

### rtl/core/stb_front.sv
// Scanner front end: consumes bytes, tracks lexer state, emits up to two tokens per item.
module stb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output stb_pkg::push_t     push
);

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUM, M_STR, M_CMT, M_OP
  } mode_t;

  mode_t mode, mode_next;
  logic [7:0] pend, pend_next;
  stb_pkg::window_t win, win_next;
  logic [stb_pkg::POS_BITS-1:0] line, line_next, col, col_next;
  logic [stb_pkg::POS_BITS-1:0] tsl, tsl_next, tsc, tsc_next, run, run_next;
  logic [stb_pkg::VAL_BITS-1:0] acc, acc_next;

  stb_pkg::tok_t fl_tok, id_tok, main_tok;
  logic fl_v, id_v, main_v, do_idle;
  logic [stb_pkg::VAL_BITS+3:0] acc_x10;
  logic [7:0] c;
  logic [7:0] dig;

  assign c = text_byte;
  assign dig = c - 8'h30;
  assign acc_x10 = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} +
                   {{(stb_pkg::VAL_BITS - 4){1'b0}}, dig};

  always_comb begin
    fl_v = 1'b1;
    fl_tok = stb_pkg::mk_tok(stb_pkg::K_IDENT, tsl, tsc, run, '0, stb_pkg::E_NONE);
    case (mode)
      M_IDENT: fl_tok.kind = stb_pkg::ident_kind(win, run);
      M_NUM: fl_tok = stb_pkg::mk_tok(stb_pkg::K_NUMBER, tsl, tsc, run, acc,
                                      stb_pkg::E_NONE);
      M_OP: begin
        if (pend == "&" || pend == "|") begin
          fl_tok = stb_pkg::mk_tok(stb_pkg::K_ERROR, line, col,
                                   stb_pkg::POS_BITS'(1), '0, stb_pkg::E_UNEXPECTED);
        end else begin
          fl_tok = stb_pkg::mk_tok(stb_pkg::single_op(pend), tsl, tsc,
                                   stb_pkg::POS_BITS'(1), '0, stb_pkg::E_NONE);
        end
      end
      M_STR: fl_tok = stb_pkg::mk_tok(stb_pkg::K_ERROR, line, col, run, '0,
                                      stb_pkg::E_UNTERMINATED);
      default: fl_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_next = mode;
    pend_next = pend;
    win_next = win;
    tsl_next = tsl;
    tsc_next = tsc;
    run_next = run;
    acc_next = acc;
    line_next = line;
    col_next = col;
    main_v = 1'b0;
    main_tok = fl_tok;
    do_idle = 1'b0;
    id_v = 1'b0;
    id_tok = fl_tok;
    if (c == 8'h0a) begin
      line_next = stb_pkg::sat_inc(line);
      col_next = stb_pkg::POS_BITS'(1);
    end else begin
      col_next = stb_pkg::sat_inc(col);
    end
    if (!end_of_text) begin
      case (mode)
        M_IDENT: begin
          if (stb_pkg::is_letter(c) || stb_pkg::is_digit(c)) begin
            if (run < stb_pkg::POS_BITS'(stb_pkg::KW_CHARS)) begin
              win_next[run[stb_pkg::KW_IB-1:0]] = c;
            end
            run_next = stb_pkg::sat_inc(run);
          end else begin
            do_idle = 1'b1;
          end
        end
        M_NUM: begin
          if (stb_pkg::is_digit(c)) begin
            acc_next = (acc_x10 > {4'b0000, stb_pkg::VAL_MAX}) ? stb_pkg::VAL_MAX
                     : acc_x10[stb_pkg::VAL_BITS-1:0];
            run_next = stb_pkg::sat_inc(run);
          end else begin
            do_idle = 1'b1;
          end
        end
        M_STR: begin
          run_next = stb_pkg::sat_inc(run);
          if (c == 8'h22) begin
            main_v = 1'b1;
            main_tok = stb_pkg::mk_tok(stb_pkg::K_IDENT, tsl, tsc, run_next, '0,
                                       stb_pkg::E_NONE);
            mode_next = M_IDLE;
          end
        end
        M_CMT: begin
          if (c == 8'h0a) mode_next = M_IDLE;
        end
        M_OP: begin
          if (pend == "/" && c == "/") begin
            mode_next = M_CMT;
          end else if (pend != "/" && ((pend == "-" && c == ">") ||
                       ((pend == "&" || pend == "|") && c == pend) ||
                       (pend != "-" && pend != "&" && pend != "|" && c == "="))) begin
            main_v = 1'b1;
            main_tok = stb_pkg::mk_tok(stb_pkg::double_op(pend), tsl, tsc,
                                       stb_pkg::POS_BITS'(2), '0, stb_pkg::E_NONE);
            mode_next = M_IDLE;
          end else begin
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
      if (do_idle) begin
        main_v = fl_v;
        mode_next = M_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
          mode_next = M_IDLE;
        end else if (stb_pkg::is_letter(c) || stb_pkg::is_digit(c) || c == 8'h22 ||
                     c == "-" || c == "!" || c == "=" || c == "<" || c == ">" ||
                     c == "&" || c == "|" || c == "/") begin
          tsl_next = line;
          tsc_next = col;
          run_next = stb_pkg::POS_BITS'(1);
          if (stb_pkg::is_letter(c)) begin
            win_next = '0;
            win_next[0] = c;
            mode_next = M_IDENT;
          end else if (stb_pkg::is_digit(c)) begin
            acc_next = {{(stb_pkg::VAL_BITS - 8){1'b0}}, dig};
            mode_next = M_NUM;
          end else if (c == 8'h22) begin
            mode_next = M_STR;
          end else begin
            pend_next = c;
            mode_next = M_OP;
          end
        end else if (stb_pkg::is_single(c)) begin
          id_v = 1'b1;
          id_tok = stb_pkg::mk_tok(stb_pkg::single_kind(c), line, col,
                                   stb_pkg::POS_BITS'(1), '0, stb_pkg::E_NONE);
        end else begin
          id_v = 1'b1;
          id_tok = stb_pkg::mk_tok(stb_pkg::K_ERROR, line_next, col_next,
                                   stb_pkg::POS_BITS'(1), '0, stb_pkg::E_UNEXPECTED);
        end
      end
    end else begin
      main_v = fl_v;
      id_v = 1'b1;
      id_tok = stb_pkg::mk_tok(stb_pkg::K_EOF, line, col, '0, '0, stb_pkg::E_NONE);
      mode_next = M_IDLE;
      pend_next = '0;
      win_next = '0;
      line_next = stb_pkg::POS_BITS'(1);
      col_next = stb_pkg::POS_BITS'(1);
      tsl_next = stb_pkg::POS_BITS'(1);
      tsc_next = stb_pkg::POS_BITS'(1);
      run_next = '0;
      acc_next = '0;
    end
  end

  always_comb begin
    push.count = 2'(main_v) + 2'(id_v);
    push.first = main_v ? main_tok : id_tok;
    push.second = id_tok;
    push.first.last = !(main_v && id_v);
    push.second.last = 1'b1;
    if (!take) push.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pend <= '0;
      win <= '0;
      line <= stb_pkg::POS_BITS'(1);
      col <= stb_pkg::POS_BITS'(1);
      tsl <= stb_pkg::POS_BITS'(1);
      tsc <= stb_pkg::POS_BITS'(1);
      run <= '0;
      acc <= '0;
    end else if (take) begin
      mode <= mode_next;
      pend <= pend_next;
      win <= win_next;
      line <= line_next;
      col <= col_next;
      tsl <= tsl_next;
      tsc <= tsc_next;
      run <= run_next;
      acc <= acc_next;
    end
  end

endmodule

### rtl/core/stb_queue.sv
// Four-entry token queue between scanner and output stage; takes up to two items per cycle.
module stb_queue (
  input  logic               clk,
  input  logic               rst,
  input  stb_pkg::push_t     push,
  output logic               room,
  input  logic               pop,
  output logic               nonempty,
  output stb_pkg::tok_t      head
);

  stb_pkg::tok_t mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  assign room = (count <= 3'd2);
  assign nonempty = (count != 3'd0);
  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wptr] <= push.first;
    if (push.count == 2'd2) mem[wptr + 2'd1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + push.count;
      if (pop) rptr <= rptr + 2'd1;
      count <= count + 3'(push.count) - 3'(pop);
    end
  end

endmodule

### rtl/core/stb_back.sv
// Output stage: registers the head token and holds it until the sink takes it.
module stb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               nonempty,
  input  stb_pkg::tok_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output stb_pkg::tok_t      out_tok
);

  assign pop = nonempty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_tok <= head;
  end

endmodule

### rtl/core/source_byte_tokenizer.sv
// Top level of the source byte tokenizer.
// Takes one source byte per cycle (tlast marks the end-of-text item, whose byte is ignored) and
// emits tokens: kind on tuser, position, length, number value and error code on tdata, and tlast
// on the final token caused by an input item. Each item produces at most two tokens into a
// four-entry queue; input is taken while at least two entries are free, so a byte per cycle is
// sustained whenever the sink keeps up and tokens average one per byte.
module source_byte_tokenizer (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // text_byte[7:0]
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [119:0]  m_axis_tdata,   // start_line[15:0], start_column[31:16],
                                        // lexeme_len[47:32], num_val[110:48],
                                        // error_code[112:111], zero[119:113]
  output logic [5:0]    m_axis_tuser,   // token_kind[5:0]
  output logic          m_axis_tlast
);

  stb_pkg::push_t push;
  stb_pkg::tok_t head, out_tok;
  logic room, pop, nonempty;

  assign s_axis_tready = room;

  stb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (s_axis_tvalid && room),
    .text_byte   (s_axis_tdata),
    .end_of_text (s_axis_tlast),
    .push        (push)
  );

  stb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  stb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_tok   (out_tok)
  );

  assign m_axis_tdata = {7'd0, out_tok.err, out_tok.value, out_tok.len, out_tok.col,
                         out_tok.line};
  assign m_axis_tuser = out_tok.kind;
  assign m_axis_tlast = out_tok.last;

endmodule
